>>> rtl/rule_based_byte_insertion_core_defines.svh
// Assertion macros shared by the byte insertion RTL
`ifndef RULE_BASED_BYTE_INSERTION_CORE_DEFINES_SVH
`define RULE_BASED_BYTE_INSERTION_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset
`define RBI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define RBI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/rbi_pkg.sv
// Shared types and constants for the byte insertion core
`timescale 1ns / 1ps

package rbi_pkg;

  localparam int BYTE_W        = 8;
  localparam int RULE_W        = 24;
  localparam int CNT_W         = 3;
  localparam int MAG_W         = 6;
  localparam int REG_IDX_W     = 3;
  localparam int RULE_SLOTS_DEF = 4;
  localparam logic [BYTE_W-1:0] MAX_FILL = 8'd63;

  localparam logic [REG_IDX_W-1:0] REG_RULE_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RULE_ZERO  = 3'd1;

  typedef logic [RULE_W-1:0] rule_t;

  typedef struct packed {
    rule_t             rule;
    logic [BYTE_W-1:0] data;
  } probe_t;

  typedef struct packed {
    logic              hit;
    logic              lead;
    logic [BYTE_W-1:0] fill;
    logic [MAG_W-1:0]  mag;
  } match_t;

endpackage

>>> rtl/rule_based_byte_insertion_core.sv
// Top level of the rule based byte insertion core
//
//  channel  | dir | fields (tdata / tlast / tuser)
//  s_axis   | in  | byte_in / string_end_in / -
//  m_axis   | out | byte_out / run_last / string_end_out
//  cfg      | in  | index 0 rule_count, 1..4 rule words
//
// An input byte passes an accept step, a rule scan over 1 to RuleSlots slots
// through the single compare unit, and 1 to 64 results through the output
// register.
// Reset clears rule count, rule words, sequencer state and output valid.
// A stalled output holds the sequencer in emission; input ready is low
// from accept until the last result is loaded.
`timescale 1ns / 1ps

module rule_based_byte_insertion_core #(
  parameter int RuleSlots = rbi_pkg::RULE_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] byte_in
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,  // [7:0] byte_out
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tuser_o,  // [0] string_end_out
  input  logic                           cfg_we_i,
  input  logic [rbi_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbi_pkg::RULE_W-1:0]     cfg_wdata_i
);

  logic [rbi_pkg::CNT_W-1:0] active;
  rbi_pkg::rule_t            rules [RuleSlots];
  rbi_pkg::probe_t           probe;
  rbi_pkg::match_t           match_res;

  rbi_cfg_regs #(
    .RuleSlots (RuleSlots)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .active_o    (active),
    .rules_o     (rules)
  );

  rbi_match_unit u_match (
    .probe_i (probe),
    .match_o (match_res)
  );

  rbi_seq #(
    .RuleSlots (RuleSlots)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o),
    .active_i   (active),
    .rules_i    (rules),
    .probe_o    (probe),
    .match_i    (match_res)
  );

endmodule

>>> rtl/rbi_cfg_regs.sv
// Configuration register file: active rule count and rule words
`timescale 1ns / 1ps

module rbi_cfg_regs #(
  parameter int RuleSlots = rbi_pkg::RULE_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbi_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbi_pkg::RULE_W-1:0]     cfg_wdata_i,
  output logic [rbi_pkg::CNT_W-1:0]      active_o,
  output rbi_pkg::rule_t                 rules_o [RuleSlots]
);

  logic [rbi_pkg::CNT_W-1:0] count_q;
  rbi_pkg::rule_t            rules_q [RuleSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == rbi_pkg::REG_RULE_COUNT)) begin
      count_q <= cfg_wdata_i[rbi_pkg::CNT_W-1:0];
    end
  end

  for (genvar g = 0; g < RuleSlots; g++) begin : g_rule
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rules_q[g] <= '0;
      end else if (cfg_we_i &&
                   (cfg_idx_i == rbi_pkg::REG_RULE_ZERO + rbi_pkg::REG_IDX_W'(g))) begin
        rules_q[g] <= cfg_wdata_i;
      end
    end
    assign rules_o[g] = rules_q[g];
  end

  // clamp to the slots actually built
  assign active_o = (count_q > rbi_pkg::CNT_W'(RuleSlots)) ? rbi_pkg::CNT_W'(RuleSlots)
                                                         : count_q;

endmodule

>>> rtl/rbi_match_unit.sv
// Shared rule compare unit: match test, count decode and saturation
`timescale 1ns / 1ps

module rbi_match_unit (
  input  rbi_pkg::probe_t probe_i,
  output rbi_pkg::match_t match_o
);

  logic [rbi_pkg::BYTE_W-1:0] cnt;
  logic [rbi_pkg::BYTE_W-1:0] mag_raw;

  always_comb begin
    cnt     = probe_i.rule[23:16];
    mag_raw = cnt[7] ? (~cnt + 8'd1) : cnt;
    match_o.hit    = (probe_i.rule[7:0] == probe_i.data);
    match_o.lead   = cnt[7];
    match_o.fill   = probe_i.rule[15:8];
    match_o.mag    = (mag_raw > rbi_pkg::MAX_FILL) ? rbi_pkg::MAX_FILL[rbi_pkg::MAG_W-1:0]
                                                   : mag_raw[rbi_pkg::MAG_W-1:0];
  end

endmodule

>>> rtl/rbi_seq.sv
// Sequencer: rule scan, fill emission and output register
`timescale 1ns / 1ps
`include "rule_based_byte_insertion_core_defines.svh"

module rbi_seq #(
  parameter int RuleSlots = rbi_pkg::RULE_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [rbi_pkg::BYTE_W-1:0]  s_tdata_i,
  input  logic                        s_tlast_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [rbi_pkg::BYTE_W-1:0]  m_tdata_o,
  output logic                        m_tlast_o,
  output logic                        m_tuser_o,
  input  logic [rbi_pkg::CNT_W-1:0]   active_i,
  input  rbi_pkg::rule_t              rules_i [RuleSlots],
  output rbi_pkg::probe_t             probe_o,
  input  rbi_pkg::match_t             match_i
);

  localparam int IdxW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [rbi_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       end_q, end_d;
  logic [rbi_pkg::BYTE_W-1:0] fill_q, fill_d;
  logic                       before_q, before_d;
  logic [rbi_pkg::MAG_W-1:0]  rem_q, rem_d;
  logic                       done_q, done_d;

  logic                       m_valid_q;
  logic [rbi_pkg::BYTE_W-1:0] m_data_q, m_data_d;
  logic                       m_last_q, m_last_d;
  logic                       m_user_q, m_user_d;

  logic                       in_fire, slot_free, out_load;
  logic [rbi_pkg::CNT_W-1:0]  idx_ext;
  logic                       in_range, last_rule;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_fire    = s_tvalid_i && s_tready_o;
  assign slot_free  = !m_valid_q || m_tready_i;

  assign idx_ext   = rbi_pkg::CNT_W'(idx_q);
  assign in_range  = idx_ext < active_i;
  assign last_rule = (idx_ext + 3'd1) >= active_i;

  assign probe_o.rule = rules_i[idx_q];
  assign probe_o.data = byte_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    byte_d   = byte_q;
    end_d    = end_q;
    fill_d   = fill_q;
    before_d = before_q;
    rem_d    = rem_q;
    done_d   = done_q;
    out_load = 1'b0;
    m_data_d = m_data_q;
    m_last_d = m_last_q;
    m_user_d = m_user_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          byte_d  = s_tdata_i;
          end_d   = s_tlast_i;
          idx_d   = '0;
          done_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (in_range && match_i.hit) begin
          fill_d   = match_i.fill;
          before_d = match_i.lead;
          rem_d    = match_i.mag;
          state_d  = S_EMIT;
        end else if (last_rule) begin
          before_d = 1'b0;
          rem_d    = '0;
          state_d  = S_EMIT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (before_q && (rem_q != '0)) begin
            m_data_d = fill_q;
            m_last_d = 1'b0;
            m_user_d = 1'b0;
            rem_d    = rem_q - rbi_pkg::MAG_W'(1);
          end else if (!done_q) begin
            m_data_d = byte_q;
            m_last_d = (rem_q == '0);
            m_user_d = (rem_q == '0) && end_q;
            done_d   = 1'b1;
            if (rem_q == '0) state_d = S_IDLE;
          end else begin
            m_data_d = fill_q;
            m_last_d = (rem_q == rbi_pkg::MAG_W'(1));
            m_user_d = (rem_q == rbi_pkg::MAG_W'(1)) && end_q;
            rem_d    = rem_q - rbi_pkg::MAG_W'(1);
            if (rem_q == rbi_pkg::MAG_W'(1)) state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    byte_q   <= byte_d;
    end_q    <= end_d;
    fill_q   <= fill_d;
    before_q <= before_d;
    rem_q    <= rem_d;
    done_q   <= done_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_user_q;

  `RBI_ASSERT(a_accept_scan, clk_i, rst_ni, in_fire |=> (state_q == S_SCAN), "request not scanned")
  `RBI_ASSERT(a_scan_range, clk_i, rst_ni, (state_q == S_SCAN) |-> (in_range || (idx_q == '0)), "scan index past active rules")
  `RBI_ASSERT_NEVER(a_end_on_last, clk_i, rst_ni, m_valid_q && m_user_q && !m_last_q, "string end without run end")

endmodule

>>> sim/rule_based_byte_insertion_core_test.sv
// Self-checking testbench for the rule based byte insertion core
`timescale 1ns / 1ps

module rule_based_byte_insertion_core_test;
  import rbi_pkg::*;

  localparam int          SLOTS        = RULE_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          REPORT_LIMIT = 10;

  localparam logic [REG_IDX_W-1:0] REG_RULE_LAST   = REG_RULE_ZERO + REG_IDX_W'(SLOTS - 1);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_RULE_LAST + 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = {REG_IDX_W{1'b1}};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              string_end;
  } beat_t;

  class insertion_scoreboard;
    logic [CNT_W-1:0] rule_count;
    rule_t            rule_word [SLOTS];
    beat_t            pending_beats [$];
    int               mismatches;
    int               beats_checked;
    int               bytes_noted;
    int               rule_hits;
    int               longest_run;

    function new();
      rule_count    = '0;
      foreach (rule_word[i]) rule_word[i] = '0;
      mismatches    = 0;
      beats_checked = 0;
      bytes_noted   = 0;
      rule_hits     = 0;
      longest_run   = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, rule_t value);
      int slot;
      slot = int'(idx) - int'(REG_RULE_ZERO);
      if (idx == REG_RULE_COUNT) begin
        rule_count = value[CNT_W-1:0];
      end else if (slot >= 0 && slot < SLOTS) begin
        rule_word[slot] = value;
      end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic string_end);
      int               active;
      int               mag;
      bit               hit;
      bit               ahead;
      logic [BYTE_W-1:0] fill;
      logic [BYTE_W-1:0] cnt;
      beat_t            beat;
      active = (int'(rule_count) > SLOTS) ? SLOTS : int'(rule_count);
      hit    = 1'b0;
      ahead  = 1'b0;
      mag    = 0;
      fill   = '0;
      for (int i = 0; i < active; i++) begin
        if (!hit && rule_word[i][7:0] == b) begin
          hit   = 1'b1;
          fill  = rule_word[i][15:8];
          cnt   = rule_word[i][23:16];
          ahead = cnt[7];
          mag   = ahead ? 256 - int'(cnt) : int'(cnt);
          if (mag > int'(MAX_FILL)) mag = int'(MAX_FILL);
        end
      end
      bytes_noted++;
      if (hit) rule_hits++;
      if (mag + 1 > longest_run) longest_run = mag + 1;
      if (ahead) begin
        for (int k = 0; k < mag; k++) begin
          beat = '{data: fill, run_last: 1'b0, string_end: 1'b0};
          pending_beats.push_back(beat);
        end
        beat = '{data: b, run_last: 1'b1, string_end: string_end};
        pending_beats.push_back(beat);
      end else begin
        beat = '{data: b, run_last: (mag == 0), string_end: (mag == 0) ? string_end : 1'b0};
        pending_beats.push_back(beat);
        for (int k = 0; k < mag; k++) begin
          beat = '{data: fill, run_last: (k == mag - 1),
                   string_end: (k == mag - 1) ? string_end : 1'b0};
          pending_beats.push_back(beat);
        end
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result beat: data %02h last %0b end %0b",
                   got.data, got.run_last, got.string_end);
        return;
      end
      want = pending_beats.pop_front();
      if (want.data != got.data || want.run_last != got.run_last ||
          want.string_end != got.string_end) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Mismatch at beat %0d: expected data %02h last %0b end %0b, got data %02h last %0b end %0b",
                   beats_checked, want.data, want.run_last, want.string_end,
                   got.data, got.run_last, got.string_end);
      end
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i  = '0;  // [7:0] byte_in
  logic                 s_axis_tlast_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [7:0]           m_axis_tdata_o;        // [7:0] byte_out
  logic                 m_axis_tlast_o;
  logic                 m_axis_tuser_o;        // [0] string_end_out
  logic                 cfg_we_i        = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i       = '0;
  rule_t                cfg_wdata_i     = '0;

  insertion_scoreboard sb = new();
  int                  send_idle_pct  = 0;
  int                  sink_stall_pct = 0;
  int unsigned         cycle_count    = 0;

  rule_based_byte_insertion_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_beat('{data: m_axis_tdata_o, run_last: m_axis_tlast_o,
                      string_end: m_axis_tuser_o});
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input rule_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_rules(input logic [CNT_W-1:0] count, input rule_t r0, input rule_t r1,
                            input rule_t r2, input rule_t r3);
    write_reg(REG_RULE_COUNT, rule_t'(count));
    write_reg(REG_RULE_ZERO,                   r0);
    write_reg(REG_RULE_ZERO + REG_IDX_W'(1),   r1);
    write_reg(REG_RULE_ZERO + REG_IDX_W'(2),   r2);
    write_reg(REG_RULE_LAST,                   r3);
    end_writes();
  endtask

  task automatic load_random_rules();
    rule_t             word [SLOTS];
    logic [BYTE_W-1:0] cnt;
    logic [CNT_W-1:0]  active;
    int                pick;
    active = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                         : CNT_W'($urandom_range(2, 4));
    for (int i = 0; i < SLOTS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) cnt = BYTE_W'($urandom_range(0, 16) - 8);
      else          cnt = BYTE_W'($urandom_range(0, 255));
      word[i] = {cnt, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255))};
      if (i > 0 && $urandom_range(0, 3) == 0) word[i][7:0] = word[i-1][7:0];
    end
    load_rules(active, word[0], word[1], word[2], word[3]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic string_end);
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= string_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, string_end);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random(input int n);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) b = sb.rule_word[$urandom_range(0, SLOTS - 1)][7:0];
      else                          b = BYTE_W'($urandom_range(0, 255));
      send_byte(b, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Run stopped after %0d cycles with %0d beats outstanding",
             cycle_count, sb.pending_beats.size());
    $display("rule_based_byte_insertion_core test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 22;
    sink_stall_pct = 64;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    load_rules(3'd7, 24'h80FF00, 24'h7F00FF, 24'h00A55A, 24'h02335A);
    for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
      write_reg(REG_IDX_W'(k), {RULE_W{1'b1}});
    end_writes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    load_rules(3'd3, 24'hC02211, 24'h404433, 24'hFF6655, 24'h018877);
    send_byte(8'h11, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h66, 1'b1);
    drain();

    load_rules(3'd4, 24'hC10201, 24'h3F0403, 24'h010605, 24'h819977);
    send_byte(8'h01, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'h05, 1'b1);
    send_byte(8'h77, 1'b1);
    drain();

    write_reg(REG_RULE_COUNT, rule_t'(1));
    end_writes();
    send_byte(8'h01, 1'b1);
    send_byte(8'h03, 1'b0);
    drain();

    load_random_rules();
    send_random(31);
    drain();

    send_idle_pct  = 64;
    sink_stall_pct = 22;
    load_random_rules();
    send_random(31);
    drain();

    send_idle_pct  = 0;
    sink_stall_pct = 0;
    load_random_rules();
    send_random(30);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes over several rule tables, %0d of them matched a rule.",
             sb.bytes_noted, sb.rule_hits);
    $display("Checked %0d output beats, longest expansion %0d beats, %0d mismatches.",
             sb.beats_checked, sb.longest_run, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("rule_based_byte_insertion_core test passed");
    end else begin
      $display("rule_based_byte_insertion_core test failed");
    end
    $finish;
  end

endmodule
